FILE: hdl/chip8_instruction_decoder_core_defines.svh
// Assertion macros shared by the checker of the instruction decoder core.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef CHIP8_INSTRUCTION_DECODER_CORE_DEFINES_SVH
`define CHIP8_INSTRUCTION_DECODER_CORE_DEFINES_SVH

// Clocked assertion, disabled while reset is low.
`define C8DEC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define C8DEC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/c8dec_pkg.sv
// Shared types, codes and lookup functions of the instruction decoder.
// Depends on nothing; used by the decode, top level and checker files.
`default_nettype none

package c8dec_pkg;

    localparam int unsigned WordW = 16;
    localparam int unsigned AddrW = 16;
    localparam int unsigned AvailW = 2;
    localparam int unsigned ClassW = 4;
    localparam int unsigned IdW = 6;

    // Analysis classes
    localparam logic [ClassW-1:0] CLS_UNK   = 4'd0;
    localparam logic [ClassW-1:0] CLS_RET   = 4'd1;
    localparam logic [ClassW-1:0] CLS_JMP   = 4'd2;
    localparam logic [ClassW-1:0] CLS_CALL  = 4'd3;
    localparam logic [ClassW-1:0] CLS_SKIP  = 4'd4;
    localparam logic [ClassW-1:0] CLS_MOV   = 4'd5;
    localparam logic [ClassW-1:0] CLS_ADD   = 4'd6;
    localparam logic [ClassW-1:0] CLS_OR    = 4'd7;
    localparam logic [ClassW-1:0] CLS_AND   = 4'd8;
    localparam logic [ClassW-1:0] CLS_XOR   = 4'd9;
    localparam logic [ClassW-1:0] CLS_SUB   = 4'd10;
    localparam logic [ClassW-1:0] CLS_SHR   = 4'd11;
    localparam logic [ClassW-1:0] CLS_SHL   = 4'd12;
    localparam logic [ClassW-1:0] CLS_KEY   = 4'd13;
    localparam logic [ClassW-1:0] CLS_LOAD  = 4'd14;
    localparam logic [ClassW-1:0] CLS_STORE = 4'd15;

    // Instruction identifiers
    localparam logic [IdW-1:0] ID_CLS      = 6'd0;
    localparam logic [IdW-1:0] ID_RET      = 6'd1;
    localparam logic [IdW-1:0] ID_SCD      = 6'd2;
    localparam logic [IdW-1:0] ID_JP       = 6'd8;
    localparam logic [IdW-1:0] ID_CALL     = 6'd9;
    localparam logic [IdW-1:0] ID_SE_IMM   = 6'd10;
    localparam logic [IdW-1:0] ID_SNE_IMM  = 6'd11;
    localparam logic [IdW-1:0] ID_SE_REG   = 6'd12;
    localparam logic [IdW-1:0] ID_LD_IMM   = 6'd13;
    localparam logic [IdW-1:0] ID_ADD_IMM  = 6'd14;
    localparam logic [IdW-1:0] ID_LD_REG   = 6'd15;
    localparam logic [IdW-1:0] ID_OR       = 6'd16;
    localparam logic [IdW-1:0] ID_AND      = 6'd17;
    localparam logic [IdW-1:0] ID_XOR      = 6'd18;
    localparam logic [IdW-1:0] ID_ADD_REG  = 6'd19;
    localparam logic [IdW-1:0] ID_SUB      = 6'd20;
    localparam logic [IdW-1:0] ID_SHR      = 6'd21;
    localparam logic [IdW-1:0] ID_SUBN     = 6'd22;
    localparam logic [IdW-1:0] ID_SHL      = 6'd23;
    localparam logic [IdW-1:0] ID_SNE_REG  = 6'd24;
    localparam logic [IdW-1:0] ID_LD_I     = 6'd25;
    localparam logic [IdW-1:0] ID_JP_V0    = 6'd26;
    localparam logic [IdW-1:0] ID_RND      = 6'd27;
    localparam logic [IdW-1:0] ID_DRW      = 6'd28;
    localparam logic [IdW-1:0] ID_SKP      = 6'd29;
    localparam logic [IdW-1:0] ID_SKNP     = 6'd30;
    localparam logic [IdW-1:0] ID_LD_V_DT  = 6'd31;
    localparam logic [IdW-1:0] ID_LD_V_K   = 6'd32;
    localparam logic [IdW-1:0] ID_LD_DT_V  = 6'd33;
    localparam logic [IdW-1:0] ID_LD_ST_V  = 6'd34;
    localparam logic [IdW-1:0] ID_ADD_I_V  = 6'd35;
    localparam logic [IdW-1:0] ID_LD_F_V   = 6'd36;
    localparam logic [IdW-1:0] ID_LD_HF_V  = 6'd37;
    localparam logic [IdW-1:0] ID_LD_B_V   = 6'd38;
    localparam logic [IdW-1:0] ID_LD_MEM_V = 6'd39;
    localparam logic [IdW-1:0] ID_LD_V_MEM = 6'd40;
    localparam logic [IdW-1:0] ID_LD_R_V   = 6'd41;
    localparam logic [IdW-1:0] ID_LD_V_R   = 6'd42;
    localparam logic [IdW-1:0] ID_INVALID  = 6'd43;

    // Fixed words and masks of the system group
    localparam logic [WordW-1:0] W_CLS       = 16'h00E0;
    localparam logic [WordW-1:0] W_RET       = 16'h00EE;
    localparam logic [WordW-1:0] M_SCD       = 16'hFFF0;
    localparam logic [WordW-1:0] W_SCD       = 16'h00C0;
    localparam logic [WordW-1:0] W_SCR_FIRST = 16'h00FB;
    localparam logic [WordW-1:0] M_NNN       = 16'h0FFF;

    // Low bytes of the key skip group
    localparam logic [7:0] KK_SKP  = 8'h9E;
    localparam logic [7:0] KK_SKNP = 8'hA1;

    // Leading nibble groups
    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SE   = 4'h3;
    localparam logic [3:0] OP_SNE  = 4'h4;
    localparam logic [3:0] OP_SER  = 4'h5;
    localparam logic [3:0] OP_LD   = 4'h6;
    localparam logic [3:0] OP_ADD  = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNER = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_JPV0 = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_DRW  = 4'hD;
    localparam logic [3:0] OP_KEY  = 4'hE;
    localparam logic [3:0] OP_MISC = 4'hF;

    // One decoded result item
    typedef struct packed {
        logic              too_short;
        logic [ClassW-1:0] op_class;
        logic [IdW-1:0]    instr_id;
        logic [3:0]        reg_x;
        logic [3:0]        reg_y;
        logic [3:0]        low_nibble;
        logic [7:0]        imm_byte;
        logic [11:0]       addr_field;
        logic              has_jump;
        logic [AddrW-1:0]  jump_target;
        logic              has_fall;
        logic [AddrW-1:0]  fall_target;
    } t_result;

    // Id and class pair from a lookup
    typedef struct packed {
        logic [IdW-1:0]    id;
        logic [ClassW-1:0] cls;
    } t_idcls;

    // ALU group 8xyN, by N
    function automatic t_idcls alu_lookup(input logic [3:0] n);
        t_idcls r;
        unique case (n)
            4'h0:    r = '{ID_LD_REG,  CLS_MOV};
            4'h1:    r = '{ID_OR,      CLS_OR};
            4'h2:    r = '{ID_AND,     CLS_AND};
            4'h3:    r = '{ID_XOR,     CLS_XOR};
            4'h4:    r = '{ID_ADD_REG, CLS_ADD};
            4'h5:    r = '{ID_SUB,     CLS_SUB};
            4'h6:    r = '{ID_SHR,     CLS_SHR};
            4'h7:    r = '{ID_SUBN,    CLS_SUB};
            4'hE:    r = '{ID_SHL,     CLS_SHL};
            default: r = '{ID_INVALID, CLS_UNK};
        endcase
        return r;
    endfunction

    // Misc group Fxkk, by kk
    function automatic t_idcls misc_lookup(input logic [7:0] kk);
        t_idcls r;
        unique case (kk)
            8'h07:   r = '{ID_LD_V_DT,  CLS_MOV};
            8'h0A:   r = '{ID_LD_V_K,   CLS_MOV};
            8'h15:   r = '{ID_LD_DT_V,  CLS_MOV};
            8'h18:   r = '{ID_LD_ST_V,  CLS_MOV};
            8'h1E:   r = '{ID_ADD_I_V,  CLS_ADD};
            8'h29:   r = '{ID_LD_F_V,   CLS_LOAD};
            8'h30:   r = '{ID_LD_HF_V,  CLS_LOAD};
            8'h33:   r = '{ID_LD_B_V,   CLS_STORE};
            8'h55:   r = '{ID_LD_MEM_V, CLS_STORE};
            8'h65:   r = '{ID_LD_V_MEM, CLS_LOAD};
            8'h75:   r = '{ID_LD_R_V,   CLS_STORE};
            8'h85:   r = '{ID_LD_V_R,   CLS_LOAD};
            default: r = '{ID_INVALID,  CLS_UNK};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/chip8_instruction_decoder_core.sv
// Path from request acceptance to result valid: input register, then result register.
// Throughput: one request per cycle; a stalled result holds and backs up into the input register.
// o_stall rises only when both the input register and the result register are full and
// the result side is stalled.
// Reset: i_rst_n synchronous, active low; clears both stage valid flags, payload is not reset.
// Depends on c8dec_pkg and c8dec_decode.
`default_nettype none

module chip8_instruction_decoder_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // request channel
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [c8dec_pkg::WordW-1:0]       i_instr_word,
    input  wire logic [c8dec_pkg::AddrW-1:0]       i_address,
    input  wire logic [c8dec_pkg::AvailW-1:0]      i_bytes_available,
    // result channel
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic                                   o_too_short,
    output logic [c8dec_pkg::ClassW-1:0]           o_op_class,
    output logic [c8dec_pkg::IdW-1:0]              o_instr_id,
    output logic [3:0]                             o_reg_x,
    output logic [3:0]                             o_reg_y,
    output logic [3:0]                             o_low_nibble,
    output logic [7:0]                             o_imm_byte,
    output logic [11:0]                            o_addr_field,
    output logic                                   o_has_jump,
    output logic [c8dec_pkg::AddrW-1:0]            o_jump_target,
    output logic                                   o_has_fall,
    output logic [c8dec_pkg::AddrW-1:0]            o_fall_target
);

    // Input register: holds the accepted request
    logic                             r_in_vld;
    logic [c8dec_pkg::WordW-1:0]      r_in_word;
    logic [c8dec_pkg::AddrW-1:0]      r_in_addr;
    logic [c8dec_pkg::AvailW-1:0]     r_in_avail;

    // Result register: holds the decoded result until taken
    logic                             r_out_vld;
    c8dec_pkg::t_result               r_out;

    c8dec_pkg::t_result               dec_result;
    logic                             out_free;
    logic                             in_free;
    logic                             in_take;
    logic                             in_move;

    // A stage may load when empty or when its content leaves in the same cycle
    assign out_free = !r_out_vld || !i_stall;
    assign in_move  = r_in_vld && out_free;
    assign in_free  = !r_in_vld || out_free;
    assign in_take  = i_valid && in_free;
    assign o_stall  = !in_free;

    c8dec_decode u_decode (
        .i_instr_word      (r_in_word),
        .i_address         (r_in_addr),
        .i_bytes_available (r_in_avail),
        .o_result          (dec_result)
    );

    // Stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            // input stage fills on a take, drains when its content moves on
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (in_move) begin
                r_in_vld <= 1'b0;
            end
            // result stage follows whatever the input stage hands over
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // Payload registers: load on advance, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word  <= i_instr_word;
            r_in_addr  <= i_address;
            r_in_avail <= i_bytes_available;
        end
        if (in_move) begin
            r_out <= dec_result;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_too_short   = r_out.too_short;
    assign o_op_class    = r_out.op_class;
    assign o_instr_id    = r_out.instr_id;
    assign o_reg_x       = r_out.reg_x;
    assign o_reg_y       = r_out.reg_y;
    assign o_low_nibble  = r_out.low_nibble;
    assign o_imm_byte    = r_out.imm_byte;
    assign o_addr_field  = r_out.addr_field;
    assign o_has_jump    = r_out.has_jump;
    assign o_jump_target = r_out.jump_target;
    assign o_has_fall    = r_out.has_fall;
    assign o_fall_target = r_out.fall_target;

endmodule

`default_nettype wire

FILE: hdl/c8dec_decode.sv
// Combinational decode of one registered instruction request into a result.
// Depends on c8dec_pkg.
`default_nettype none

module c8dec_decode (
    input  wire logic [c8dec_pkg::WordW-1:0]  i_instr_word,
    input  wire logic [c8dec_pkg::AddrW-1:0]  i_address,
    input  wire logic [c8dec_pkg::AvailW-1:0] i_bytes_available,
    output c8dec_pkg::t_result                o_result
);

    logic [c8dec_pkg::AddrW-1:0]  skip_t;
    logic [c8dec_pkg::AddrW-1:0]  next_t;
    logic [c8dec_pkg::AddrW-1:0]  nnn_t;
    logic [7:0]                   kk;
    c8dec_pkg::t_idcls            alu;
    c8dec_pkg::t_idcls            misc;
    logic                         ctl_skip;

    assign kk     = i_instr_word[7:0];
    assign skip_t = i_address + c8dec_pkg::AddrW'(4);
    assign next_t = i_address + c8dec_pkg::AddrW'(2);
    assign nnn_t  = i_instr_word & c8dec_pkg::M_NNN;
    assign alu    = c8dec_pkg::alu_lookup(i_instr_word[3:0]);
    assign misc   = c8dec_pkg::misc_lookup(kk);

    always_comb begin
        o_result             = '0;
        o_result.reg_x       = i_instr_word[11:8];
        o_result.reg_y       = i_instr_word[7:4];
        o_result.low_nibble  = i_instr_word[3:0];
        o_result.imm_byte    = kk;
        o_result.addr_field  = i_instr_word[11:0];
        o_result.instr_id    = c8dec_pkg::ID_INVALID;
        o_result.op_class    = c8dec_pkg::CLS_UNK;
        ctl_skip             = 1'b0;

        unique case (i_instr_word[15:12])
            c8dec_pkg::OP_SYS: begin
                priority if (i_instr_word == c8dec_pkg::W_CLS) begin
                    o_result.instr_id = c8dec_pkg::ID_CLS;
                end else if (i_instr_word == c8dec_pkg::W_RET) begin
                    o_result.instr_id = c8dec_pkg::ID_RET;
                    o_result.op_class = c8dec_pkg::CLS_RET;
                end else if ((i_instr_word & c8dec_pkg::M_SCD) == c8dec_pkg::W_SCD) begin
                    o_result.instr_id = c8dec_pkg::ID_SCD;
                end else if (i_instr_word >= c8dec_pkg::W_SCR_FIRST
                             && i_instr_word[15:8] == 8'h00) begin
                    // scr, scl, exit, low, high map straight from the low three bits
                    o_result.instr_id = {3'b000, i_instr_word[2:0]};
                end else begin
                    o_result.instr_id = c8dec_pkg::ID_INVALID;
                end
            end
            c8dec_pkg::OP_JP: begin
                o_result.instr_id    = c8dec_pkg::ID_JP;
                o_result.op_class    = c8dec_pkg::CLS_JMP;
                o_result.has_jump    = 1'b1;
                o_result.jump_target = nnn_t;
            end
            c8dec_pkg::OP_CALL: begin
                o_result.instr_id    = c8dec_pkg::ID_CALL;
                o_result.op_class    = c8dec_pkg::CLS_CALL;
                o_result.has_jump    = 1'b1;
                o_result.jump_target = nnn_t;
                o_result.has_fall    = 1'b1;
                o_result.fall_target = next_t;
            end
            c8dec_pkg::OP_SE: begin
                o_result.instr_id = c8dec_pkg::ID_SE_IMM;
                o_result.op_class = c8dec_pkg::CLS_SKIP;
                ctl_skip          = 1'b1;
            end
            c8dec_pkg::OP_SNE: begin
                o_result.instr_id = c8dec_pkg::ID_SNE_IMM;
                o_result.op_class = c8dec_pkg::CLS_SKIP;
                ctl_skip          = 1'b1;
            end
            c8dec_pkg::OP_SER: begin
                o_result.instr_id = c8dec_pkg::ID_SE_REG;
                o_result.op_class = c8dec_pkg::CLS_SKIP;
                ctl_skip          = 1'b1;
            end
            c8dec_pkg::OP_LD: begin
                o_result.instr_id = c8dec_pkg::ID_LD_IMM;
                o_result.op_class = c8dec_pkg::CLS_MOV;
            end
            c8dec_pkg::OP_ADD: begin
                o_result.instr_id = c8dec_pkg::ID_ADD_IMM;
                o_result.op_class = c8dec_pkg::CLS_ADD;
            end
            c8dec_pkg::OP_ALU: begin
                o_result.instr_id = alu.id;
                o_result.op_class = alu.cls;
            end
            c8dec_pkg::OP_SNER: begin
                // keep the id for any nibble; only the plain form is a skip
                o_result.instr_id = c8dec_pkg::ID_SNE_REG;
                if (i_instr_word[3:0] == 4'h0) begin
                    o_result.op_class = c8dec_pkg::CLS_SKIP;
                    ctl_skip          = 1'b1;
                end
            end
            c8dec_pkg::OP_LDI: begin
                o_result.instr_id = c8dec_pkg::ID_LD_I;
                o_result.op_class = c8dec_pkg::CLS_MOV;
            end
            c8dec_pkg::OP_JPV0: begin
                o_result.instr_id    = c8dec_pkg::ID_JP_V0;
                o_result.op_class    = c8dec_pkg::CLS_JMP;
                o_result.has_jump    = 1'b1;
                o_result.jump_target = nnn_t;
            end
            c8dec_pkg::OP_RND: begin
                o_result.instr_id = c8dec_pkg::ID_RND;
            end
            c8dec_pkg::OP_DRW: begin
                o_result.instr_id = c8dec_pkg::ID_DRW;
            end
            c8dec_pkg::OP_KEY: begin
                if (kk == c8dec_pkg::KK_SKP) begin
                    o_result.instr_id = c8dec_pkg::ID_SKP;
                    o_result.op_class = c8dec_pkg::CLS_KEY;
                    ctl_skip          = 1'b1;
                end else if (kk == c8dec_pkg::KK_SKNP) begin
                    o_result.instr_id = c8dec_pkg::ID_SKNP;
                    o_result.op_class = c8dec_pkg::CLS_KEY;
                    ctl_skip          = 1'b1;
                end
            end
            c8dec_pkg::OP_MISC: begin
                o_result.instr_id = misc.id;
                o_result.op_class = misc.cls;
            end
            default: begin
                o_result.instr_id = c8dec_pkg::ID_INVALID;
            end
        endcase

        if (ctl_skip) begin
            o_result.has_jump    = 1'b1;
            o_result.jump_target = skip_t;
            o_result.has_fall    = 1'b1;
            o_result.fall_target = next_t;
        end

        // fewer than two bytes: flag it and clear everything else
        if (!i_bytes_available[1]) begin
            o_result           = '0;
            o_result.too_short = 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/c8dec_checker.sv
// Port-level checks on the instruction decoder core, bound to its top level.
// Depends on c8dec_pkg and chip8_instruction_decoder_core_defines.svh.
`default_nettype none

`include "chip8_instruction_decoder_core_defines.svh"

module c8dec_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_stall,
    input wire logic                         o_valid,
    input wire logic                         i_stall,
    input wire logic                         o_too_short,
    input wire logic [c8dec_pkg::ClassW-1:0] o_op_class,
    input wire logic [c8dec_pkg::IdW-1:0]    o_instr_id,
    input wire logic                         o_has_jump,
    input wire logic [c8dec_pkg::AddrW-1:0]  o_jump_target,
    input wire logic                         o_has_fall,
    input wire logic [c8dec_pkg::AddrW-1:0]  o_fall_target
);

    // A stalled result holds
    `C8DEC_ASSERT(a_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_instr_id) && $stable(o_jump_target) && $stable(o_fall_target), "stalled result changed")

    // A short request reads as a cleared class and id, with no targets
    `C8DEC_ASSERT(a_short, i_clk, i_rst_n, o_valid && o_too_short |-> o_op_class == c8dec_pkg::CLS_UNK && o_instr_id == c8dec_pkg::ID_CLS && !o_has_jump && !o_has_fall, "short result not cleared")

    // Invalid words carry no class and no targets
    `C8DEC_ASSERT(a_invalid, i_clk, i_rst_n, o_valid && o_instr_id == c8dec_pkg::ID_INVALID |-> o_op_class == c8dec_pkg::CLS_UNK && !o_has_jump && !o_has_fall, "invalid word has class or target")

    // A fall-through only comes with a taken target, and unused targets read zero
    `C8DEC_ASSERT(a_targets, i_clk, i_rst_n, o_valid |-> (!o_has_fall || o_has_jump) && (o_has_jump || o_jump_target == '0) && (o_has_fall || o_fall_target == '0), "target flags inconsistent")

    // With the result side free, the request side never stalls
    `C8DEC_ASSERT(a_nostall, i_clk, i_rst_n, !o_valid |-> !o_stall, "request stalled with empty result stage")

endmodule

bind chip8_instruction_decoder_core c8dec_checker u_c8dec_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_too_short   (o_too_short),
    .o_op_class    (o_op_class),
    .o_instr_id    (o_instr_id),
    .o_has_jump    (o_has_jump),
    .o_jump_target (o_jump_target),
    .o_has_fall    (o_has_fall),
    .o_fall_target (o_fall_target)
);

`default_nettype wire
